// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, removed when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/psa_pkg.sv =====
// ---------------------------------------------------------------------------
// Pooled slot allocator package
// Sizes, codes and the command and status types shared by the modules.
// ---------------------------------------------------------------------------
package psa_pkg;
    localparam int NUM_TYPES      = 4;
    localparam int SLOTS_PER_TYPE = 16;
    localparam int TYPE_W         = 2;
    localparam int SLOT_W         = 4;
    localparam int IDX_W          = TYPE_W + SLOT_W;
    localparam int TOTAL_SLOTS    = NUM_TYPES * SLOTS_PER_TYPE;
    localparam int SIZE_W         = 5;
    localparam int HANDLE_W       = 31;
    localparam int TIME_W         = 32;
    localparam int LIFE_W         = 16;
    localparam int OP_W           = 2;
    localparam int STATUS_W       = 3;

    localparam logic [OP_W-1:0] OP_ACTIVATE = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP     = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_ACTIVATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EVICTED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNCONFIG  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_STOPPED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EXPIRED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_TICK_IDLE = 3'd6;

    typedef struct packed {
        logic              latch;
        logic              pop_rd;
        logic              pop_wr;
        logic              scan_rd;
        logic              finish;
        logic [IDX_W-1:0]  addr;
    } psa_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TYPE_W-1:0] ftype;
        logic              can_pop;
    } psa_stat_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   act_time;
        logic [LIFE_W-1:0]   life;
    } psa_slot_t;

    function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] s);
        if (s > SIZE_W'(SLOTS_PER_TYPE))
            sat_size = SIZE_W'(SLOTS_PER_TYPE);
        else
            sat_size = s;
    endfunction
endpackage

// ===== hdl/psa_ctrl.sv =====
// ---------------------------------------------------------------------------
// Pooled slot allocator controller
// Sequences pop, scan and finish steps and drives the slot scan address.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module psa_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [psa_pkg::OP_W-1:0]  opcode,
    input  psa_pkg::psa_stat_t        stat,
    output psa_pkg::psa_cmd_t         cmd,
    output logic                      busy
);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_POP_RD = 3'd2;
    localparam logic [2:0] S_POP_WR = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_DRAIN  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]                state_reg, state_next;
    logic [psa_pkg::IDX_W-1:0] addr_reg, addr_next;
    logic                      scan_end;

    assign busy = (state_reg != S_IDLE);
    assign scan_end = (stat.op == psa_pkg::OP_ACTIVATE)
        ? (addr_reg[psa_pkg::SLOT_W-1:0] == {psa_pkg::SLOT_W{1'b1}})
        : (addr_reg == {psa_pkg::IDX_W{1'b1}});

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        cmd        = '0;
        cmd.addr   = addr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    if (opcode != psa_pkg::OP_NONE)
                        state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.op == psa_pkg::OP_ACTIVATE)
                begin
                    if (stat.can_pop)
                        state_next = S_POP_RD;
                    else
                    begin
                        state_next = S_SCAN;
                        addr_next  = {stat.ftype, {psa_pkg::SLOT_W{1'b0}}};
                    end
                end
                else
                begin
                    state_next = S_SCAN;
                    addr_next  = '0;
                end
            end
            S_POP_RD:
            begin
                cmd.pop_rd = 1'b1;
                state_next = S_POP_WR;
            end
            S_POP_WR:
            begin
                cmd.pop_wr = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (scan_end)
                    state_next = S_DRAIN;
                else
                    addr_next = addr_reg + 1'b1;
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    `ASSERT_NEXT(a_pop_pair, clk, rst_n, state_reg == S_POP_RD, state_reg == S_POP_WR)
    `ASSERT_ALWAYS(a_pop_ok, clk, rst_n, !cmd.pop_rd || stat.can_pop)
    `ASSERT_NEXT(a_drain, clk, rst_n, state_reg == S_DRAIN, state_reg == S_FINISH)
endmodule

// ===== hdl/psa_dp.sv =====
// ---------------------------------------------------------------------------
// Pooled slot allocator datapath
// Slot memory, free stacks, counters, scan evaluation and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module psa_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [psa_pkg::OP_W-1:0]        opcode,
    input  logic [psa_pkg::TYPE_W-1:0]      fire_type,
    input  logic [psa_pkg::LIFE_W-1:0]      lifetime,
    input  logic [psa_pkg::HANDLE_W-1:0]    handle,
    input  logic                            cfg_we,
    input  logic [psa_pkg::TYPE_W-1:0]      cfg_index,
    input  logic [psa_pkg::SIZE_W-1:0]      cfg_data,
    input  psa_pkg::psa_cmd_t               cmd,
    output psa_pkg::psa_stat_t              stat,
    output logic                            result_valid,
    output logic [psa_pkg::STATUS_W-1:0]    status,
    output logic [psa_pkg::HANDLE_W-1:0]    handle_out,
    output logic [psa_pkg::TYPE_W-1:0]      type_out,
    output logic [psa_pkg::SLOT_W-1:0]      slot,
    output logic                            last
);
    localparam int T = psa_pkg::NUM_TYPES;
    localparam int N = psa_pkg::TOTAL_SLOTS;
    localparam int SW = psa_pkg::SLOT_W;
    localparam int IW = psa_pkg::IDX_W;

    psa_pkg::psa_slot_t slot_mem [N];
    logic [SW-1:0]      stack_mem [N];

    logic [psa_pkg::SIZE_W-1:0]   size_reg [T];
    logic [psa_pkg::SIZE_W-1:0]   fc_reg [T];
    logic [N-1:0]                 active_reg;
    logic [N-1:0]                 stk_vld_reg;
    logic [psa_pkg::HANDLE_W-1:0] next_handle_reg;
    logic [psa_pkg::TIME_W-1:0]   time_now_reg;
    logic [psa_pkg::OP_W-1:0]     op_reg;
    logic [psa_pkg::TYPE_W-1:0]   ft_reg;
    logic [psa_pkg::LIFE_W-1:0]   life_reg;
    logic [psa_pkg::HANDLE_W-1:0] h_reg;
    logic                         eval_reg;
    logic [IW-1:0]                eval_addr_reg;
    psa_pkg::psa_slot_t           rd_reg;
    logic [SW-1:0]                stk_q_reg;
    logic                         stk_vld_q_reg;
    logic [SW-1:0]                pos_q_reg;
    logic                         found_reg;
    logic [IW-1:0]                best_reg;
    logic [psa_pkg::TIME_W-1:0]   best_time_reg;
    logic                         pend_reg;
    logic [psa_pkg::HANDLE_W-1:0] pend_h_reg;
    logic [IW-1:0]                pend_addr_reg;
    logic                         rv_reg;
    logic [psa_pkg::STATUS_W-1:0] st_reg;
    logic [psa_pkg::HANDLE_W-1:0] ho_reg;
    logic [psa_pkg::TYPE_W-1:0]   to_reg;
    logic [SW-1:0]                so_reg;
    logic                         last_reg;

    logic [psa_pkg::SIZE_W-1:0]   ft_size, ft_fc, ev_size, ev_fc;
    logic [psa_pkg::TYPE_W-1:0]   ev_t;
    logic [SW-1:0]                ev_i, pop_slot, pop_pos;
    logic                         ev_hit, rel_en, grant, push_ok;
    logic [IW-1:0]                grant_addr;
    logic [psa_pkg::TIME_W-1:0]   age;
    logic                         e_vld, e_last;
    logic [psa_pkg::STATUS_W-1:0] e_st;
    logic [psa_pkg::HANDLE_W-1:0] e_h, nh_inc;
    logic [psa_pkg::TYPE_W-1:0]   e_t;
    logic [SW-1:0]                e_s;

    assign ft_size = psa_pkg::sat_size(size_reg[ft_reg]);
    assign ft_fc   = fc_reg[ft_reg];
    assign stat.op = op_reg;
    assign stat.ftype = ft_reg;
    assign stat.can_pop = (ft_size != '0) && (ft_fc != '0);

    assign ev_t    = eval_addr_reg[IW-1:SW];
    assign ev_i    = eval_addr_reg[SW-1:0];
    assign ev_size = psa_pkg::sat_size(size_reg[ev_t]);
    assign ev_fc   = fc_reg[ev_t];
    assign ev_hit  = eval_reg && ({1'b0, ev_i} < ev_size) && active_reg[eval_addr_reg];
    assign age     = time_now_reg - rd_reg.act_time;
    assign pop_pos = SW'(ft_fc - 1'b1);
    assign pop_slot = stk_vld_q_reg ? stk_q_reg : pos_q_reg;
    assign push_ok = ev_fc < ev_size;
    assign nh_inc  = next_handle_reg + 1'b1;

    always_comb
    begin
        rel_en = 1'b0;
        unique case (op_reg)
            psa_pkg::OP_STOP:
                rel_en = ev_hit && !found_reg && (rd_reg.handle == h_reg);
            psa_pkg::OP_TICK:
                rel_en = ev_hit && (rd_reg.life != '0)
                    && (age >= {{(psa_pkg::TIME_W-psa_pkg::LIFE_W){1'b0}}, rd_reg.life});
            default:
                rel_en = 1'b0;
        endcase
    end

    always_comb
    begin
        grant      = 1'b0;
        grant_addr = {ft_reg, pop_slot};
        e_vld  = 1'b0;
        e_last = 1'b1;
        e_st   = psa_pkg::ST_TICK_IDLE;
        e_h    = '0;
        e_t    = '0;
        e_s    = '0;
        if (cmd.pop_wr)
        begin
            grant = 1'b1;
            e_vld = 1'b1;
            e_st  = psa_pkg::ST_ACTIVATED;
            e_h   = next_handle_reg;
            e_t   = ft_reg;
            e_s   = pop_slot;
        end
        else if (cmd.finish)
        begin
            e_vld = 1'b1;
            unique case (op_reg)
                psa_pkg::OP_ACTIVATE:
                begin
                    e_t = ft_reg;
                    if (found_reg)
                    begin
                        grant      = 1'b1;
                        grant_addr = {ft_reg, best_reg[SW-1:0]};
                        e_st = psa_pkg::ST_EVICTED;
                        e_h  = next_handle_reg;
                        e_s  = best_reg[SW-1:0];
                    end
                    else
                        e_st = psa_pkg::ST_UNCONFIG;
                end
                psa_pkg::OP_STOP:
                begin
                    if (found_reg)
                    begin
                        e_st = psa_pkg::ST_STOPPED;
                        e_h  = h_reg;
                        e_t  = best_reg[IW-1:SW];
                        e_s  = best_reg[SW-1:0];
                    end
                    else
                        e_st = psa_pkg::ST_NOTFOUND;
                end
                default:
                begin
                    if (pend_reg)
                    begin
                        e_st = psa_pkg::ST_EXPIRED;
                        e_h  = pend_h_reg;
                        e_t  = pend_addr_reg[IW-1:SW];
                        e_s  = pend_addr_reg[SW-1:0];
                    end
                end
            endcase
        end
        else if (rel_en && (op_reg == psa_pkg::OP_TICK) && pend_reg)
        begin
            e_vld  = 1'b1;
            e_last = 1'b0;
            e_st   = psa_pkg::ST_EXPIRED;
            e_h    = pend_h_reg;
            e_t    = pend_addr_reg[IW-1:SW];
            e_s    = pend_addr_reg[SW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (grant)
            slot_mem[grant_addr] <= '{handle: next_handle_reg, act_time: time_now_reg,
                                      life: life_reg};
        if (cmd.scan_rd)
            rd_reg <= slot_mem[cmd.addr];
        if (rel_en && push_ok)
            stack_mem[{ev_t, ev_fc[SW-1:0]}] <= ev_i;
        if (cmd.pop_rd)
        begin
            stk_q_reg <= stack_mem[{ft_reg, pop_pos}];
            pos_q_reg <= pop_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < T; t++)
            begin
                size_reg[t] <= '0;
                fc_reg[t]   <= '0;
            end
            active_reg      <= '0;
            stk_vld_reg     <= '0;
            next_handle_reg <= psa_pkg::HANDLE_W'(1);
            time_now_reg    <= '0;
            op_reg          <= psa_pkg::OP_NONE;
            ft_reg          <= '0;
            life_reg        <= '0;
            h_reg           <= '0;
            eval_reg        <= 1'b0;
            eval_addr_reg   <= '0;
            stk_vld_q_reg   <= 1'b0;
            found_reg       <= 1'b0;
            best_reg        <= '0;
            best_time_reg   <= '0;
            pend_reg        <= 1'b0;
            pend_h_reg      <= '0;
            pend_addr_reg   <= '0;
            rv_reg          <= 1'b0;
            st_reg          <= '0;
            ho_reg          <= '0;
            to_reg          <= '0;
            so_reg          <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg[cfg_index] <= cfg_data;
                fc_reg[cfg_index]   <= psa_pkg::sat_size(cfg_data);
                active_reg[{cfg_index, {SW{1'b0}}} +: psa_pkg::SLOTS_PER_TYPE] <= '0;
                stk_vld_reg[{cfg_index, {SW{1'b0}}} +: psa_pkg::SLOTS_PER_TYPE] <= '0;
            end
            if (cmd.latch)
            begin
                op_reg    <= opcode;
                ft_reg    <= fire_type;
                life_reg  <= lifetime;
                h_reg     <= handle;
                found_reg <= 1'b0;
                pend_reg  <= 1'b0;
                if (opcode == psa_pkg::OP_TICK)
                    time_now_reg <= time_now_reg + 1'b1;
            end
            if (cmd.pop_rd)
            begin
                fc_reg[ft_reg] <= ft_fc - 1'b1;
                stk_vld_q_reg  <= stk_vld_reg[{ft_reg, pop_pos}];
            end
            if (grant)
            begin
                active_reg[grant_addr] <= 1'b1;
                next_handle_reg <= (nh_inc == '0) ? psa_pkg::HANDLE_W'(1) : nh_inc;
            end
            eval_reg      <= cmd.scan_rd;
            eval_addr_reg <= cmd.addr;
            if (ev_hit && (op_reg == psa_pkg::OP_ACTIVATE)
                && (!found_reg || (rd_reg.act_time < best_time_reg)))
            begin
                found_reg     <= 1'b1;
                best_reg      <= eval_addr_reg;
                best_time_reg <= rd_reg.act_time;
            end
            if (rel_en)
            begin
                active_reg[eval_addr_reg] <= 1'b0;
                if (push_ok)
                begin
                    stk_vld_reg[{ev_t, ev_fc[SW-1:0]}] <= 1'b1;
                    fc_reg[ev_t] <= ev_fc + 1'b1;
                end
                if (op_reg == psa_pkg::OP_STOP)
                begin
                    found_reg <= 1'b1;
                    best_reg  <= eval_addr_reg;
                end
                else
                begin
                    pend_reg      <= 1'b1;
                    pend_h_reg    <= rd_reg.handle;
                    pend_addr_reg <= eval_addr_reg;
                end
            end
            rv_reg <= e_vld;
            if (e_vld)
            begin
                st_reg   <= e_st;
                ho_reg   <= e_h;
                to_reg   <= e_t;
                so_reg   <= e_s;
                last_reg <= e_last;
            end
        end
    end

    assign result_valid = rv_reg;
    assign status       = st_reg;
    assign handle_out   = ho_reg;
    assign type_out     = to_reg;
    assign slot         = so_reg;
    assign last         = last_reg;

    `ASSERT_ALWAYS(a_fc0, clk, rst_n, fc_reg[0] <= psa_pkg::sat_size(size_reg[0]))
    `ASSERT_ALWAYS(a_fc1, clk, rst_n, fc_reg[1] <= psa_pkg::sat_size(size_reg[1]))
    `ASSERT_ALWAYS(a_handle_nz, clk, rst_n, next_handle_reg != '0)
endmodule

// ===== hdl/pooled_slot_allocator_oldest_evict.sv =====
// ---------------------------------------------------------------------------
// Pooled slot allocator with oldest eviction
// Four slot pools with free stacks, handle grant, stop and lifetime expiry.
// ---------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low; opcode selects
// activate, stop by handle or tick, and opcode three is dropped at once.
// Each result beat is shown for one cycle with result_valid high, and last
// marks the final beat of a command. The receiver cannot stall.
// An activate from a nonempty free stack passes the decide, pop read and pop
// write states and returns its beat from the result register. An activate
// with an empty stack scans its pool of sixteen slots and answers at finish.
// Stop and tick scan all sixty-four slots through the single read port of
// the slot memory, one slot a cycle, and end with the finish beat; tick
// expiry beats appear during the scan, one a cycle at most.
// Pool size registers are written through cfg_we, cfg_index and cfg_data
// only by the user while idle, not enforced; a write empties that pool at once.
// Reset clears all pools to unconfigured, the handle counter to one and
// the time to zero; no memory clearing pass is needed.
// ---------------------------------------------------------------------------
module pooled_slot_allocator_oldest_evict (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [psa_pkg::OP_W-1:0]        opcode,
    input  logic [psa_pkg::TYPE_W-1:0]      fire_type,
    input  logic [psa_pkg::LIFE_W-1:0]      lifetime,
    input  logic [psa_pkg::HANDLE_W-1:0]    handle,
    input  logic                            cfg_we,
    input  logic [psa_pkg::TYPE_W-1:0]      cfg_index,
    input  logic [psa_pkg::SIZE_W-1:0]      cfg_data,
    output logic                            result_valid,
    output logic [psa_pkg::STATUS_W-1:0]    status,
    output logic [psa_pkg::HANDLE_W-1:0]    handle_out,
    output logic [psa_pkg::TYPE_W-1:0]      type_out,
    output logic [psa_pkg::SLOT_W-1:0]      slot,
    output logic                            last
);
    psa_pkg::psa_cmd_t  cmd;
    psa_pkg::psa_stat_t stat;

    psa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    psa_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .opcode       (opcode),
        .fire_type    (fire_type),
        .lifetime     (lifetime),
        .handle       (handle),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .status       (status),
        .handle_out   (handle_out),
        .type_out     (type_out),
        .slot         (slot),
        .last         (last)
    );
endmodule
